### rtl/core/dsfp_pkg.sv
`default_nettype none

package dsfp_pkg;

   localparam int CNT_W  = 32;
   localparam int BYTE_W = 8;

   localparam logic [BYTE_W-1:0] START_MARKER_RESET = 8'd126;
   localparam logic [BYTE_W-1:0] END_MARKER_RESET   = 8'd231;
   localparam logic [BYTE_W-1:0] DMX_LABEL_RESET    = 8'd6;
   localparam logic [BYTE_W-1:0] DMX_START_CODE     = 8'h00;

   typedef enum logic [1:0] {
      REQ_FEED  = 2'd0,
      REQ_READ  = 2'd1,
      REQ_RESET = 2'd2,
      REQ_CLEAR = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_NEED_MORE = 2'd0,
      ST_COMPLETE  = 2'd1,
      ST_RESYNC    = 2'd2
   } parse_status_type;

   typedef enum logic [1:0] {
      CSR_START_MARKER = 2'd0,
      CSR_END_MARKER   = 2'd1,
      CSR_DMX_LABEL    = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_WAIT  = 3'd0,
      PH_LABEL = 3'd1,
      PH_LENLO = 3'd2,
      PH_LENHI = 3'd3,
      PH_DATA  = 3'd4,
      PH_END   = 3'd5
   } phase_type;

   typedef struct packed {
      logic [CNT_W-1:0]  oversize_seen;
      logic [CNT_W-1:0]  resyncs_seen;
      logic [CNT_W-1:0]  frames_seen;
      logic              channel_valid;
      logic [BYTE_W-1:0] channel_value;
      logic [9:0]        channel_count;
      logic              is_dmx_frame;
      logic [9:0]        frame_length;
      logic [BYTE_W-1:0] frame_label;
      logic [1:0]        parse_status;
   } rsp_word_type;

endpackage

`default_nettype wire

### rtl/core/dmx_serial_frame_parser_core.sv
// Serial frame parser for a DMX-over-USB style byte stream.
// Every request on the req_ channel (kind in req_tuser) produces exactly one
// response on the rsp_ channel, in request order. A feed request pushes one
// serial byte through the frame parser; payload bytes are written into a
// payload RAM. A read request returns the channel byte that follows the start
// code, as last written to the payload RAM. Reset-parser and clear-counter
// requests act on the parser state and on the three event counters.
// A response passes through the middle stage, which takes the registered
// payload RAM read, and then through the output register. While the receiver
// takes responses, a request is accepted in every cycle, so the sustained rate
// is one request per cycle; the RAM write port takes one payload byte per
// cycle and its read port one channel read per cycle.
// When the receiver stalls, the output register holds its response and the
// middle stage still takes one request; req_tready then drops until the
// output frees up.
// The csr_ port writes the start marker, end marker and DMX label registers
// and should be used only while no request is in flight. Synchronous reset
// restores the register defaults, the parser to hunting for a start byte, and
// clears the latched frame and counters; the payload RAM is not cleared.
`default_nettype none

module dmx_serial_frame_parser_core
   import dsfp_pkg::*;
#(
   parameter int PAYLOAD_DEPTH = 513
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [23:0]  req_tdata,   // rx_byte[7:0], channel_index[16:8], zero pad
   input  wire  [1:0]   req_tuser,   // req_type[1:0]
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // parse_status[1:0], frame_label[9:2], frame_length[19:10], is_dmx_frame[20],
   // channel_count[30:21], channel_value[38:31], channel_valid[39],
   // frames_seen[71:40], resyncs_seen[103:72], oversize_seen[135:104]
   output logic [135:0] rsp_tdata,
   input  wire          csr_we,
   input  wire  [1:0]   csr_index,
   input  wire  [7:0]   csr_wdata
);

   localparam int AW      = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
   localparam int DEPTH_W = $clog2(PAYLOAD_DEPTH + 1);
   localparam int LEN_W   = (DEPTH_W > 10) ? DEPTH_W : 10;
   localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(PAYLOAD_DEPTH);

   logic [BYTE_W-1:0] start_marker_ff, end_marker_ff, dmx_label_ff;

   phase_type         phase_ff, phase_in;
   logic [BYTE_W-1:0] pend_label_ff, pend_label_in;
   logic [LEN_W-1:0]  pend_len_ff, pend_len_in;
   logic [LEN_W-1:0]  stored_ff, stored_in;
   logic [BYTE_W-1:0] latch_label_ff, latch_label_in;
   logic [LEN_W-1:0]  latch_len_ff, latch_len_in;
   logic [BYTE_W-1:0] byte0_ff, byte0_in;
   logic [CNT_W-1:0]  frame_cnt_ff, frame_cnt_in;
   logic [CNT_W-1:0]  resync_cnt_ff, resync_cnt_in;
   logic [CNT_W-1:0]  over_cnt_ff, over_cnt_in;
   parse_status_type  status_in;

   logic              accept;
   req_kind_type      req_kind;
   logic [BYTE_W-1:0] rx_byte;
   logic [8:0]        chan_idx;
   logic [15:0]       len_full;
   logic [LEN_W-1:0]  stored_inc;
   logic [LEN_W-1:0]  idx_ext, idx_inc, count_in;
   logic              dmx_in, valid_in;
   logic              wr_en, rd_en;

   logic              s1_valid_ff;
   rsp_word_type      s1_ff, s1_in;
   logic              rsp_valid_ff;
   rsp_word_type      rsp_ff, rsp_in;
   logic [BYTE_W-1:0] ram_rd_data;
   logic              out_free, s1_move;

   assign req_kind = req_kind_type'(req_tuser);
   assign rx_byte  = req_tdata[7:0];
   assign chan_idx = req_tdata[16:8];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_move    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= START_MARKER_RESET;
         end_marker_ff   <= END_MARKER_RESET;
         dmx_label_ff    <= DMX_LABEL_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_START_MARKER: start_marker_ff <= csr_wdata;
            CSR_END_MARKER:   end_marker_ff   <= csr_wdata;
            CSR_DMX_LABEL:    dmx_label_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign len_full   = {rx_byte, pend_len_ff[7:0]};
   assign stored_inc = stored_ff + 1'b1;

   always_comb begin
      phase_in       = phase_ff;
      pend_label_in  = pend_label_ff;
      pend_len_in    = pend_len_ff;
      stored_in      = stored_ff;
      latch_label_in = latch_label_ff;
      latch_len_in   = latch_len_ff;
      byte0_in       = byte0_ff;
      frame_cnt_in   = frame_cnt_ff;
      resync_cnt_in  = resync_cnt_ff;
      over_cnt_in    = over_cnt_ff;
      status_in      = ST_NEED_MORE;
      wr_en          = 1'b0;
      if (accept) begin
         unique case (req_kind)
            REQ_FEED: begin
               unique case (phase_ff)
                  PH_LABEL: begin
                     pend_label_in = rx_byte;
                     phase_in      = PH_LENLO;
                  end
                  PH_LENLO: begin
                     pend_len_in = LEN_W'(rx_byte);
                     phase_in    = PH_LENHI;
                  end
                  PH_LENHI: begin
                     if (len_full > 16'(PAYLOAD_DEPTH)) begin
                        over_cnt_in   = over_cnt_ff + 1'b1;
                        resync_cnt_in = resync_cnt_ff + 1'b1;
                        status_in     = ST_RESYNC;
                        phase_in      = PH_WAIT;
                        pend_label_in = '0;
                        pend_len_in   = '0;
                        stored_in     = '0;
                     end else begin
                        pend_len_in = len_full[LEN_W-1:0];
                        stored_in   = '0;
                        phase_in    = (len_full == 16'd0) ? PH_END : PH_DATA;
                     end
                  end
                  PH_DATA: begin
                     wr_en     = 1'b1;
                     stored_in = stored_inc;
                     if (stored_ff == '0) begin
                        byte0_in = rx_byte;
                     end
                     if (stored_inc >= pend_len_ff) begin
                        phase_in = PH_END;
                     end
                  end
                  PH_END: begin
                     if (rx_byte == end_marker_ff) begin
                        latch_label_in = pend_label_ff;
                        latch_len_in   = pend_len_ff;
                        frame_cnt_in   = frame_cnt_ff + 1'b1;
                        status_in      = ST_COMPLETE;
                        phase_in       = PH_WAIT;
                     end else begin
                        resync_cnt_in = resync_cnt_ff + 1'b1;
                        status_in     = ST_RESYNC;
                        phase_in      = (rx_byte == start_marker_ff) ? PH_LABEL : PH_WAIT;
                     end
                     pend_label_in = '0;
                     pend_len_in   = '0;
                     stored_in     = '0;
                  end
                  default: begin
                     phase_in = (rx_byte == start_marker_ff) ? PH_LABEL : PH_WAIT;
                  end
               endcase
            end
            REQ_RESET: begin
               phase_in      = PH_WAIT;
               pend_label_in = '0;
               pend_len_in   = '0;
               stored_in     = '0;
            end
            REQ_CLEAR: begin
               frame_cnt_in  = '0;
               resync_cnt_in = '0;
               over_cnt_in   = '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_label_ff  <= '0;
         pend_len_ff    <= '0;
         stored_ff      <= '0;
         latch_label_ff <= '0;
         latch_len_ff   <= '0;
         frame_cnt_ff   <= '0;
         resync_cnt_ff  <= '0;
         over_cnt_ff    <= '0;
      end else begin
         pend_label_ff  <= pend_label_in;
         pend_len_ff    <= pend_len_in;
         stored_ff      <= stored_in;
         latch_label_ff <= latch_label_in;
         latch_len_ff   <= latch_len_in;
         frame_cnt_ff   <= frame_cnt_in;
         resync_cnt_ff  <= resync_cnt_in;
         over_cnt_ff    <= over_cnt_in;
      end
   end

   // Copy of payload entry zero, so the start code is known without a RAM read.
   always_ff @(posedge clock) begin
      byte0_ff <= byte0_in;
   end

   assign idx_ext  = {{(LEN_W - 9){1'b0}}, chan_idx};
   assign idx_inc  = idx_ext + 1'b1;
   assign dmx_in   = (latch_label_in == dmx_label_ff) && (latch_len_in != '0) &&
                     (byte0_in == DMX_START_CODE);
   assign count_in = dmx_in ? (latch_len_in - 1'b1) : '0;
   assign valid_in = (req_kind == REQ_READ) && (idx_ext < count_in) && (idx_inc < DEPTH_LEN);
   assign rd_en    = accept && (req_kind == REQ_READ);

   dsfp_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (PAYLOAD_DEPTH)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (stored_ff[AW-1:0]),
      .wr_data (rx_byte),
      .rd_en   (rd_en),
      .rd_addr (idx_inc[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      s1_in               = '0;
      s1_in.parse_status  = status_in;
      s1_in.frame_label   = latch_label_in;
      s1_in.frame_length  = latch_len_in[9:0];
      s1_in.is_dmx_frame  = dmx_in;
      s1_in.channel_count = count_in[9:0];
      s1_in.channel_valid = valid_in;
      s1_in.frames_seen   = frame_cnt_in;
      s1_in.resyncs_seen  = resync_cnt_in;
      s1_in.oversize_seen = over_cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      rsp_in               = s1_ff;
      rsp_in.channel_value = s1_ff.channel_valid ? ram_rd_data : '0;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (s1_move) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

`ifndef SYNTHESIS
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |=> s1_valid_ff && $stable(s1_ff))
      else $error("middle stage lost a response while the output was full");

   a_end_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_END |-> stored_ff == pend_len_ff)
      else $error("end byte expected before the payload was complete");

   a_data_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> stored_ff < pend_len_ff)
      else $error("payload phase with no bytes left to store");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      latch_len_ff <= DEPTH_LEN && (phase_ff != PH_DATA || pend_len_ff <= DEPTH_LEN))
      else $error("frame length beyond the payload buffer");
`endif

endmodule

`default_nettype wire

### rtl/core/dsfp_ram.sv
`default_nettype none

module dsfp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 513
) (
   input  wire                                    clock,
   input  wire                                    wr_en,
   input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire [WIDTH-1:0]                        wr_data,
   input  wire                                    rd_en,
   input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
